// File: rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Request kinds carried in the input tuser field
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_PROBE = 2'd3
  } req_kind_t;

  // Bus sequencer steps
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_SDA  = 5'd1,
    PH_ST_SCL  = 5'd2,
    PH_WB_SDA  = 5'd3,
    PH_WB_SCLH = 5'd4,
    PH_WB_SCLL = 5'd5,
    PH_WA_SDA  = 5'd6,
    PH_WA_SCLH = 5'd7,
    PH_WA_SMP  = 5'd8,
    PH_WA_SCLL = 5'd9,
    PH_WA_REL  = 5'd10,
    PH_RB_SCLL0 = 5'd11,
    PH_RB_SCLH = 5'd12,
    PH_RB_SCLL = 5'd13,
    PH_RA_SDA  = 5'd14,
    PH_RA_SCLH = 5'd15,
    PH_RA_SCLL = 5'd16,
    PH_SP_SDA  = 5'd17,
    PH_SP_SCL  = 5'd18,
    PH_SP_SDAH = 5'd19
  } phase_t;

  // Which byte of the transfer is on the bus
  typedef enum logic [2:0] {
    STG_PROBE = 3'd0,
    STG_WADDR = 3'd1,
    STG_WDATA = 3'd2,
    STG_RADDR = 3'd3,
    STG_RDATA = 3'd4
  } stage_t;

  // Completion status
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_DEV = 2'd1,
    STS_NO_ACK = 2'd2
  } status_t;

  localparam int QUEUE_DEPTH = 2;

  // Classified request between front end and sequencer
  typedef struct packed {
    req_kind_t  kind;
    logic [6:0] address;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } req_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    status_t    status;
    logic [5:0] byte_total;
    logic       probe_ack;
  } res_t;

endpackage

// File: rtl/i2cm_front.sv
module i2cm_front #(
  parameter int MAX_BYTES = 16
) (
  input  logic              in_valid,
  input  logic [1:0]        in_user,   // req_type
  input  logic [31:0]       in_data,   // address, write_count, read_count, write_byte, sda_in
  output logic              push_valid,
  output i2cm_pkg::req_t    push_data
);

  logic [4:0] wc;
  logic [4:0] rc;

  assign wc = in_data[11:7];
  assign rc = in_data[16:12];

  // Decode the request kind
  assign push_data.kind = i2cm_pkg::req_kind_t'(in_user);

  // Unpack fields and clamp the byte counts to the buffer size
  assign push_data.address     = in_data[6:0];
  assign push_data.write_count = (32'(wc) > MAX_BYTES) ? 5'(MAX_BYTES) : wc;
  assign push_data.read_count  = (32'(rc) > MAX_BYTES) ? 5'(MAX_BYTES) : rc;
  assign push_data.write_byte  = in_data[24:17];
  assign push_data.sda_in      = in_data[25];
  assign push_valid            = in_valid;

endmodule

// File: rtl/i2cm_queue.sv
module i2cm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  i2cm_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output i2cm_pkg::req_t pop_data
);

  localparam int QD  = i2cm_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  i2cm_pkg::req_t slot_r [QD];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push;
  logic           pop;

  assign push_ready = (count_r != QCW'(QD));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/i2cm_seq.sv
module i2cm_seq #(
  parameter int MAX_BYTES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  i2cm_pkg::req_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output i2cm_pkg::res_t res
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int FW = $clog2(MAX_BYTES + 1);

  i2cm_pkg::phase_t  phase_r, phase_nxt;
  i2cm_pkg::stage_t  stage_r, stage_nxt;
  i2cm_pkg::status_t fail_r, fail_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [6:0]        target_r, target_nxt;
  logic [4:0]        writes_r, writes_nxt;
  logic [4:0]        reads_r, reads_nxt;
  logic [5:0]        moved_r, moved_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ack_r, ack_nxt;
  logic              probe_r, probe_nxt;
  logic              out_valid_r;
  i2cm_pkg::res_t    res_r, res_nxt;

  logic [7:0]        buf_mem [MAX_BYTES];
  logic [7:0]        rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic [6:0]        rd_pos;
  logic              mem_we;

  logic              step;
  logic              is_tick;
  logic              is_idle;
  logic [3:0]        bit_inc;
  logic [4:0]        writes_dec;
  logic [4:0]        reads_dec;
  logic              cont_read;

  assign item_ready = !out_valid_r || res_ready;
  assign step       = item_valid && item_ready;
  assign is_tick    = (item.kind == i2cm_pkg::REQ_TICK);
  assign is_idle    = (phase_r == i2cm_pkg::PH_IDLE);
  assign bit_inc    = bit_r + 4'd1;
  assign writes_dec = writes_r - 5'd1;
  assign reads_dec  = (reads_r != '0) ? reads_r - 5'd1 : reads_r;
  assign cont_read  = (fail_r == i2cm_pkg::STS_OK) && (reads_r != '0) &&
                      ((stage_r == i2cm_pkg::STG_WADDR) || (stage_r == i2cm_pkg::STG_WDATA));

  // Prefetch the byte sent after the current one: the next data byte once data is going
  assign rd_pos  = {1'b0, moved_r} + ((stage_r == i2cm_pkg::STG_WDATA) ? 7'd1 : 7'd0);
  assign rd_addr = (32'(rd_pos) >= MAX_BYTES) ? '0 : AW'(rd_pos);

  // Next bus step
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (is_tick) begin
        unique case (phase_r)
          i2cm_pkg::PH_ST_SDA:  phase_nxt = i2cm_pkg::PH_ST_SCL;
          i2cm_pkg::PH_ST_SCL:  phase_nxt = i2cm_pkg::PH_WB_SDA;
          i2cm_pkg::PH_WB_SDA:  phase_nxt = i2cm_pkg::PH_WB_SCLH;
          i2cm_pkg::PH_WB_SCLH: phase_nxt = i2cm_pkg::PH_WB_SCLL;
          i2cm_pkg::PH_WB_SCLL: begin
            phase_nxt = (bit_inc >= 4'd8) ? i2cm_pkg::PH_WA_SDA : i2cm_pkg::PH_WB_SDA;
          end
          i2cm_pkg::PH_WA_SDA:  phase_nxt = i2cm_pkg::PH_WA_SCLH;
          i2cm_pkg::PH_WA_SCLH: phase_nxt = i2cm_pkg::PH_WA_SMP;
          i2cm_pkg::PH_WA_SMP:  phase_nxt = i2cm_pkg::PH_WA_SCLL;
          i2cm_pkg::PH_WA_SCLL: phase_nxt = i2cm_pkg::PH_WA_REL;
          i2cm_pkg::PH_WA_REL: begin
            if (stage_r == i2cm_pkg::STG_PROBE || !ack_r) begin
              phase_nxt = i2cm_pkg::PH_SP_SDA;
            end else if (stage_r == i2cm_pkg::STG_WADDR) begin
              phase_nxt = i2cm_pkg::PH_WB_SDA;
            end else if (stage_r == i2cm_pkg::STG_RADDR) begin
              phase_nxt = i2cm_pkg::PH_RB_SCLL0;
            end else begin
              phase_nxt = (writes_dec != '0) ? i2cm_pkg::PH_WB_SDA : i2cm_pkg::PH_SP_SDA;
            end
          end
          i2cm_pkg::PH_RB_SCLL0: phase_nxt = i2cm_pkg::PH_RB_SCLH;
          i2cm_pkg::PH_RB_SCLH:  phase_nxt = i2cm_pkg::PH_RB_SCLL;
          i2cm_pkg::PH_RB_SCLL: begin
            phase_nxt = (bit_inc >= 4'd8) ? i2cm_pkg::PH_RA_SDA : i2cm_pkg::PH_RB_SCLH;
          end
          i2cm_pkg::PH_RA_SDA:  phase_nxt = i2cm_pkg::PH_RA_SCLH;
          i2cm_pkg::PH_RA_SCLH: phase_nxt = i2cm_pkg::PH_RA_SCLL;
          i2cm_pkg::PH_RA_SCLL: begin
            phase_nxt = (reads_dec != '0) ? i2cm_pkg::PH_RB_SCLL0 : i2cm_pkg::PH_SP_SDA;
          end
          i2cm_pkg::PH_SP_SDA: phase_nxt = i2cm_pkg::PH_SP_SCL;
          i2cm_pkg::PH_SP_SCL: phase_nxt = i2cm_pkg::PH_SP_SDAH;
          i2cm_pkg::PH_SP_SDAH: begin
            phase_nxt = cont_read ? i2cm_pkg::PH_ST_SDA : i2cm_pkg::PH_IDLE;
          end
          default: phase_nxt = i2cm_pkg::PH_IDLE;
        endcase
      end else if (is_idle) begin
        if (item.kind == i2cm_pkg::REQ_PROBE) begin
          phase_nxt = i2cm_pkg::PH_ST_SDA;
        end else if (item.kind == i2cm_pkg::REQ_START &&
                     (item.write_count != '0 || item.read_count != '0)) begin
          phase_nxt = i2cm_pkg::PH_ST_SDA;
        end
      end
    end
  end

  // Pin drive, counters, buffer access and the result item
  always_comb begin
    stage_nxt  = stage_r;
    fail_nxt   = fail_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    target_nxt = target_r;
    writes_nxt = writes_r;
    reads_nxt  = reads_r;
    moved_nxt  = moved_r;
    fill_nxt   = fill_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    probe_nxt  = probe_r;
    mem_we     = 1'b0;
    res_nxt    = '0;
    if (step) begin
      if (is_tick) begin
        case (phase_r)
          i2cm_pkg::PH_ST_SDA: sda_nxt = 1'b0;
          i2cm_pkg::PH_ST_SCL: begin
            scl_nxt = 1'b0;
            bit_nxt = '0;
          end
          i2cm_pkg::PH_WB_SDA:  sda_nxt = shift_r[7];
          i2cm_pkg::PH_WB_SCLH: scl_nxt = 1'b1;
          i2cm_pkg::PH_WB_SCLL: begin
            scl_nxt   = 1'b0;
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_inc;
          end
          i2cm_pkg::PH_WA_SDA:  sda_nxt = 1'b1;
          i2cm_pkg::PH_WA_SCLH: scl_nxt = 1'b1;
          i2cm_pkg::PH_WA_SMP:  ack_nxt = !item.sda_in;
          i2cm_pkg::PH_WA_SCLL: scl_nxt = 1'b0;
          i2cm_pkg::PH_WA_REL: begin
            sda_nxt = 1'b1;
            if (stage_r == i2cm_pkg::STG_PROBE) begin
              probe_nxt = ack_r;
            end else if (stage_r == i2cm_pkg::STG_WADDR || stage_r == i2cm_pkg::STG_RADDR) begin
              if (!ack_r) begin
                fail_nxt = i2cm_pkg::STS_NO_DEV;
              end else if (stage_r == i2cm_pkg::STG_WADDR) begin
                stage_nxt = i2cm_pkg::STG_WDATA;
                shift_nxt = rd_data_r;
                bit_nxt   = '0;
              end else begin
                stage_nxt = i2cm_pkg::STG_RDATA;
              end
            end else if (!ack_r) begin
              fail_nxt = i2cm_pkg::STS_NO_ACK;
            end else begin
              moved_nxt  = moved_r + 6'd1;
              writes_nxt = writes_dec;
              if (writes_dec != '0) begin
                shift_nxt = rd_data_r;
                bit_nxt   = '0;
              end
            end
          end
          i2cm_pkg::PH_RB_SCLL0: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            bit_nxt   = '0;
            shift_nxt = '0;
          end
          i2cm_pkg::PH_RB_SCLH: begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_r[6:0], item.sda_in};
          end
          i2cm_pkg::PH_RB_SCLL: begin
            scl_nxt = 1'b0;
            bit_nxt = bit_inc;
          end
          i2cm_pkg::PH_RA_SDA:  sda_nxt = (reads_r > 5'd1) ? 1'b0 : 1'b1;
          i2cm_pkg::PH_RA_SCLH: scl_nxt = 1'b1;
          i2cm_pkg::PH_RA_SCLL: begin
            scl_nxt            = 1'b0;
            res_nxt.read_byte  = shift_r;
            res_nxt.read_valid = 1'b1;
            moved_nxt          = moved_r + 6'd1;
            reads_nxt          = reads_dec;
          end
          i2cm_pkg::PH_SP_SDA: sda_nxt = 1'b0;
          i2cm_pkg::PH_SP_SCL: scl_nxt = 1'b1;
          i2cm_pkg::PH_SP_SDAH: begin
            sda_nxt = 1'b1;
            if (cont_read) begin
              stage_nxt = i2cm_pkg::STG_RADDR;
              shift_nxt = {target_r, 1'b1};
            end else begin
              res_nxt.done_res = 1'b1;
              if (stage_r == i2cm_pkg::STG_PROBE) begin
                res_nxt.probe_ack = probe_r;
              end else begin
                res_nxt.status     = fail_r;
                res_nxt.byte_total = moved_r;
              end
            end
          end
          default: ;
        endcase
      end else if (is_idle) begin
        if (item.kind == i2cm_pkg::REQ_LOAD) begin
          // Append to the write buffer unless it is full
          if (fill_r < FW'(MAX_BYTES)) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end else begin
          target_nxt = item.address;
          moved_nxt  = '0;
          fail_nxt   = i2cm_pkg::STS_OK;
          ack_nxt    = 1'b0;
          probe_nxt  = 1'b0;
          if (item.kind == i2cm_pkg::REQ_PROBE) begin
            stage_nxt  = i2cm_pkg::STG_PROBE;
            writes_nxt = '0;
            reads_nxt  = '0;
            shift_nxt  = {item.address, 1'b0};
          end else begin
            fill_nxt   = '0;
            writes_nxt = item.write_count;
            reads_nxt  = item.read_count;
            if (item.write_count != '0) begin
              stage_nxt = i2cm_pkg::STG_WADDR;
              shift_nxt = {item.address, 1'b0};
            end else if (item.read_count != '0) begin
              stage_nxt = i2cm_pkg::STG_RADDR;
              shift_nxt = {item.address, 1'b1};
            end else begin
              stage_nxt        = i2cm_pkg::STG_RDATA;
              res_nxt.done_res = 1'b1;
            end
          end
        end
      end
    end
    res_nxt.scl_level = scl_nxt;
    res_nxt.sda_level = sda_nxt;
    res_nxt.busy_res  = (phase_nxt != i2cm_pkg::PH_IDLE);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cm_pkg::PH_IDLE;
      stage_r  <= i2cm_pkg::STG_PROBE;
      fail_r   <= i2cm_pkg::STS_OK;
      bit_r    <= '0;
      shift_r  <= '0;
      target_r <= '0;
      writes_r <= '0;
      reads_r  <= '0;
      moved_r  <= '0;
      fill_r   <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      ack_r    <= 1'b0;
      probe_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      stage_r  <= stage_nxt;
      fail_r   <= fail_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      target_r <= target_nxt;
      writes_r <= writes_nxt;
      reads_r  <= reads_nxt;
      moved_r  <= moved_nxt;
      fill_r   <= fill_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      ack_r    <= ack_nxt;
      probe_r  <= probe_nxt;
    end
  end

  // Write buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[fill_r[AW-1:0]] <= item.write_byte;
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_ready) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("finished result still reports busy");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != i2cm_pkg::STS_OK) |-> res_r.done_res)
    else $error("error status without done");

  a_read_mid_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.read_valid |-> res_r.busy_res && !res_r.done_res)
    else $error("received byte outside an active transfer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_BYTES))
    else $error("write buffer fill beyond capacity");

endmodule

// File: rtl/i2c_master_transfer.sv
// Path: an accepted request is stored in a queue slot, then stepped by the sequencer
//   into the output register, where its result is held until taken.
// Throughput: one request per cycle while results are taken, set by the single-step bus
//   sequencer; a two-entry queue decouples input acceptance from output stalls.
// Reset: synchronous, active low; sequencer idle, both lines released, counts
//   cleared; write buffer contents are undefined until loaded, with no clearing pass.
module i2c_master_transfer #(
  parameter int MAX_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // address, write_count, read_count, write_byte, sda_in
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // scl_level, sda_level, read_byte, busy_res, status,
                                  // byte_total, probe_ack
  output logic        out_tuser,  // read_valid
  output logic        out_tlast   // done_res
);

  logic           push_valid;
  i2cm_pkg::req_t push_data;
  logic           q_valid;
  logic           q_ready;
  i2cm_pkg::req_t q_data;
  i2cm_pkg::res_t res;

  i2cm_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .in_valid   (in_tvalid),
    .in_user    (in_tuser),
    .in_data    (in_tdata),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (in_tready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  i2cm_seq #(
    .MAX_BYTES (MAX_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_data),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // Pack the result fields
  assign out_tdata = {4'b0, res.probe_ack, res.byte_total, res.status, res.busy_res,
                      res.read_byte, res.sda_level, res.scl_level};
  assign out_tuser = res.read_valid;
  assign out_tlast = res.done_res;

endmodule

// File: test/i2c_master_transfer_tb.sv
module i2c_master_transfer_tb;

  localparam int BUF_DEPTH = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int NO_NACK = -1;
  localparam int PRINT_CAP = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // address, write_count, read_count, write_byte, sda_in
  logic [1:0]  in_tuser = i2cm_pkg::REQ_TICK;  // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // scl_level, sda_level, read_byte, busy_res, status,
                                // byte_total, probe_ack
  logic        out_tuser;       // read_valid
  logic        out_tlast;       // done_res

  i2c_master_transfer #(.MAX_BYTES(BUF_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Bus sequencer mirror
  i2cm_pkg::phase_t  bus_phase = i2cm_pkg::PH_IDLE;
  i2cm_pkg::stage_t  bus_stage = i2cm_pkg::STG_PROBE;
  i2cm_pkg::status_t bus_fail = i2cm_pkg::STS_OK;
  int         bit_cnt = 0;
  logic [7:0] shift_reg = '0;
  logic [6:0] dev_addr = '0;
  int         wr_left = 0;
  int         rd_left = 0;
  int         moved = 0;
  logic [7:0] wr_buf [BUF_DEPTH];
  int         buf_fill = 0;
  int         buf_loaded = 0;
  logic       scl_drv = 1'b1;
  logic       sda_drv = 1'b1;
  logic       ack_latch = 1'b0;
  logic       probe_latch = 1'b0;

  i2cm_pkg::res_t bus_results [$];

  int n_errors = 0;
  int n_checked = 0;
  int n_effective = 0;
  int n_transfers = 0;
  int n_probes = 0;
  int n_bytes_read = 0;
  int n_failed = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;

  function automatic int clamp_count(input int c);
    return (c > BUF_DEPTH) ? BUF_DEPTH : c;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("mismatch on result %0d: %s got %0d want %0d", n_checked, field, got, want);
  endtask

  task automatic arm_read();
    bus_stage = i2cm_pkg::STG_RADDR;
    shift_reg = {dev_addr, 1'b1};
    bus_phase = i2cm_pkg::PH_ST_SDA;
  endtask

  // Advance the mirror by one accepted request and queue the expected result
  task automatic predict_bus(input i2cm_pkg::req_kind_t kind, input logic [6:0] addr,
                             input logic [4:0] wc, input logic [4:0] rc,
                             input logic [7:0] wb, input logic sda);
    i2cm_pkg::res_t r;
    r = '0;
    if (kind == i2cm_pkg::REQ_TICK) begin
      n_effective++;
      case (bus_phase)
        i2cm_pkg::PH_ST_SDA: begin
          sda_drv = 1'b0;
          bus_phase = i2cm_pkg::PH_ST_SCL;
        end
        i2cm_pkg::PH_ST_SCL: begin
          scl_drv = 1'b0;
          bit_cnt = 0;
          bus_phase = i2cm_pkg::PH_WB_SDA;
        end
        i2cm_pkg::PH_WB_SDA: begin
          sda_drv = shift_reg[7];
          bus_phase = i2cm_pkg::PH_WB_SCLH;
        end
        i2cm_pkg::PH_WB_SCLH: begin
          scl_drv = 1'b1;
          bus_phase = i2cm_pkg::PH_WB_SCLL;
        end
        i2cm_pkg::PH_WB_SCLL: begin
          scl_drv = 1'b0;
          shift_reg = {shift_reg[6:0], 1'b0};
          bit_cnt++;
          bus_phase = (bit_cnt >= 8) ? i2cm_pkg::PH_WA_SDA : i2cm_pkg::PH_WB_SDA;
        end
        i2cm_pkg::PH_WA_SDA: begin
          sda_drv = 1'b1;
          bus_phase = i2cm_pkg::PH_WA_SCLH;
        end
        i2cm_pkg::PH_WA_SCLH: begin
          scl_drv = 1'b1;
          bus_phase = i2cm_pkg::PH_WA_SMP;
        end
        i2cm_pkg::PH_WA_SMP: begin
          ack_latch = ~sda;
          bus_phase = i2cm_pkg::PH_WA_SCLL;
        end
        i2cm_pkg::PH_WA_SCLL: begin
          scl_drv = 1'b0;
          bus_phase = i2cm_pkg::PH_WA_REL;
        end
        i2cm_pkg::PH_WA_REL: begin
          sda_drv = 1'b1;
          // decide what follows the byte just sent
          if (bus_stage == i2cm_pkg::STG_PROBE) begin
            probe_latch = ack_latch;
            bus_phase = i2cm_pkg::PH_SP_SDA;
          end else if (bus_stage == i2cm_pkg::STG_WADDR ||
                       bus_stage == i2cm_pkg::STG_RADDR) begin
            if (!ack_latch) begin
              bus_fail = i2cm_pkg::STS_NO_DEV;
              bus_phase = i2cm_pkg::PH_SP_SDA;
            end else if (bus_stage == i2cm_pkg::STG_WADDR) begin
              bus_stage = i2cm_pkg::STG_WDATA;
              shift_reg = wr_buf[moved % BUF_DEPTH];
              bit_cnt = 0;
              bus_phase = i2cm_pkg::PH_WB_SDA;
            end else begin
              bus_stage = i2cm_pkg::STG_RDATA;
              bus_phase = i2cm_pkg::PH_RB_SCLL0;
            end
          end else if (!ack_latch) begin
            bus_fail = i2cm_pkg::STS_NO_ACK;
            bus_phase = i2cm_pkg::PH_SP_SDA;
          end else begin
            moved++;
            wr_left--;
            if (wr_left > 0) begin
              shift_reg = wr_buf[moved % BUF_DEPTH];
              bit_cnt = 0;
              bus_phase = i2cm_pkg::PH_WB_SDA;
            end else begin
              bus_phase = i2cm_pkg::PH_SP_SDA;
            end
          end
        end
        i2cm_pkg::PH_RB_SCLL0: begin
          scl_drv = 1'b0;
          sda_drv = 1'b1;
          bit_cnt = 0;
          shift_reg = '0;
          bus_phase = i2cm_pkg::PH_RB_SCLH;
        end
        i2cm_pkg::PH_RB_SCLH: begin
          scl_drv = 1'b1;
          shift_reg = {shift_reg[6:0], sda};
          bus_phase = i2cm_pkg::PH_RB_SCLL;
        end
        i2cm_pkg::PH_RB_SCLL: begin
          scl_drv = 1'b0;
          bit_cnt++;
          bus_phase = (bit_cnt >= 8) ? i2cm_pkg::PH_RA_SDA : i2cm_pkg::PH_RB_SCLH;
        end
        i2cm_pkg::PH_RA_SDA: begin
          sda_drv = (rd_left > 1) ? 1'b0 : 1'b1;
          bus_phase = i2cm_pkg::PH_RA_SCLH;
        end
        i2cm_pkg::PH_RA_SCLH: begin
          scl_drv = 1'b1;
          bus_phase = i2cm_pkg::PH_RA_SCLL;
        end
        i2cm_pkg::PH_RA_SCLL: begin
          scl_drv = 1'b0;
          r.read_byte = shift_reg;
          r.read_valid = 1'b1;
          n_bytes_read++;
          moved++;
          if (rd_left > 0) rd_left--;
          bus_phase = (rd_left > 0) ? i2cm_pkg::PH_RB_SCLL0 : i2cm_pkg::PH_SP_SDA;
        end
        i2cm_pkg::PH_SP_SDA: begin
          sda_drv = 1'b0;
          bus_phase = i2cm_pkg::PH_SP_SCL;
        end
        i2cm_pkg::PH_SP_SCL: begin
          scl_drv = 1'b1;
          bus_phase = i2cm_pkg::PH_SP_SDAH;
        end
        i2cm_pkg::PH_SP_SDAH: begin
          sda_drv = 1'b1;
          if (bus_fail == i2cm_pkg::STS_OK && rd_left > 0 &&
              (bus_stage == i2cm_pkg::STG_WADDR || bus_stage == i2cm_pkg::STG_WDATA)) begin
            arm_read();
          end else begin
            bus_phase = i2cm_pkg::PH_IDLE;
            r.done_res = 1'b1;
            if (bus_stage == i2cm_pkg::STG_PROBE) begin
              r.probe_ack = probe_latch;
              n_probes++;
            end else begin
              r.status = bus_fail;
              r.byte_total = moved[5:0];
              n_transfers++;
              if (bus_fail != i2cm_pkg::STS_OK) n_failed++;
            end
          end
        end
        default: bus_phase = i2cm_pkg::PH_IDLE;
      endcase
    end else if (bus_phase == i2cm_pkg::PH_IDLE) begin
      if (kind == i2cm_pkg::REQ_LOAD) begin
        // a load into a full buffer is dropped
        if (buf_fill < BUF_DEPTH) begin
          n_effective++;
          wr_buf[buf_fill] = wb;
          buf_fill++;
          if (buf_fill > buf_loaded) buf_loaded = buf_fill;
        end
      end else begin
        n_effective++;
        dev_addr = addr;
        moved = 0;
        bus_fail = i2cm_pkg::STS_OK;
        ack_latch = 1'b0;
        probe_latch = 1'b0;
        if (kind == i2cm_pkg::REQ_PROBE) begin
          bus_stage = i2cm_pkg::STG_PROBE;
          wr_left = 0;
          rd_left = 0;
          shift_reg = {addr, 1'b0};
          bus_phase = i2cm_pkg::PH_ST_SDA;
        end else begin
          buf_fill = 0;
          wr_left = clamp_count(int'(wc));
          rd_left = clamp_count(int'(rc));
          if (wr_left > 0) begin
            bus_stage = i2cm_pkg::STG_WADDR;
            shift_reg = {addr, 1'b0};
            bus_phase = i2cm_pkg::PH_ST_SDA;
          end else if (rd_left > 0) begin
            arm_read();
          end else begin
            // nothing to move: finish on the spot
            bus_stage = i2cm_pkg::STG_RDATA;
            r.done_res = 1'b1;
            n_transfers++;
          end
        end
      end
    end
    r.scl_level = scl_drv;
    r.sda_level = sda_drv;
    r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
    bus_results.push_back(r);
  endtask

  // Send one request in bursts with random gaps, then predict it once accepted
  task automatic send_req(input i2cm_pkg::req_kind_t kind, input logic [6:0] addr,
                          input logic [4:0] wc, input logic [4:0] rc,
                          input logic [7:0] wb, input logic sda);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, sda, wb, rc, wc, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_bus(kind, addr, wc, rc, wb, sda);
  endtask

  task automatic send_tick(input logic sda);
    send_req(i2cm_pkg::REQ_TICK, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
             5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), sda);
  endtask

  // Hold off the sender until every expected result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (bus_results.size() != 0);
  endtask

  // Tick the bus until idle; NACK the given acknowledge sample, optionally slip in commands
  task automatic run_bus(input int nack_at, input bit noisy);
    int  ack_idx;
    logic sda;
    i2cm_pkg::req_kind_t k;
    ack_idx = 0;
    while (bus_phase != i2cm_pkg::PH_IDLE) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        k = i2cm_pkg::req_kind_t'($urandom_range(1, 3));
        send_req(k, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end else begin
        if (bus_phase == i2cm_pkg::PH_WA_SMP) begin
          sda = (ack_idx == nack_at);
          ack_idx++;
        end else begin
          sda = 1'($urandom_range(0, 1));
        end
        send_tick(sda);
      end
    end
  endtask

  task automatic run_transfer(input logic [6:0] addr, input int wc, input int rc,
                              input int nload, input int nack_at, input bit noisy);
    int wc_use;
    wc_use = wc;
    // never let the write phase reach an entry that was never loaded
    if (clamp_count(wc_use) > buf_loaded) wc_use = buf_loaded;
    repeat (nload) send_req(i2cm_pkg::REQ_LOAD, 7'($urandom_range(0, 127)),
                            5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_req(i2cm_pkg::REQ_START, addr, 5'(wc_use), 5'(rc), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    run_bus(nack_at, noisy);
  endtask

  task automatic run_probe(input logic [6:0] addr, input bit nack, input bit noisy);
    send_req(i2cm_pkg::REQ_PROBE, addr, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    run_bus(nack ? 0 : NO_NACK, noisy);
  endtask

  task automatic test_idle_ticks();
    send_req(i2cm_pkg::REQ_TICK, 7'h7f, 5'h1f, 5'h1f, 8'hff, 1'b1);
    send_req(i2cm_pkg::REQ_TICK, 7'h00, 5'h00, 5'h00, 8'h00, 1'b0);
  endtask

  task automatic test_buffer_fill();
    // sixteen loads fill the buffer, the seventeenth is dropped
    send_req(i2cm_pkg::REQ_LOAD, 7'h00, 5'h00, 5'h00, 8'h00, 1'b0);
    send_req(i2cm_pkg::REQ_LOAD, 7'h7f, 5'h1f, 5'h1f, 8'hff, 1'b1);
    repeat (BUF_DEPTH - 2) send_req(i2cm_pkg::REQ_LOAD, 7'h00, 5'h00, 5'h00,
                                    8'($urandom_range(0, 255)), 1'b0);
    send_req(i2cm_pkg::REQ_LOAD, 7'h00, 5'h00, 5'h00, 8'ha5, 1'b0);
  endtask

  task automatic test_zero_counts();
    send_req(i2cm_pkg::REQ_START, 7'h7f, 5'd0, 5'd0, 8'h00, 1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_probe();
    run_probe(7'h7f, 1'b0, 1'b0);
    run_probe(7'h00, 1'b1, 1'b0);
  endtask

  task automatic test_write_read();
    run_transfer(7'h55, 1, 1, 1, NO_NACK, 1'b0);
  endtask

  task automatic test_address_nack();
    // a refused write address also skips the read phase
    run_transfer(7'h7f, 1, 1, 0, 0, 1'b0);
    run_transfer(7'h01, 0, 2, 0, 0, 1'b1);
  endtask

  task automatic test_data_nack();
    run_transfer(7'h33, 2, 1, 2, 2, 1'b0);
  endtask

  task automatic test_saturated_counts();
    run_transfer(7'h6c, 0, 31, 0, NO_NACK, 1'b0);
    wait_drained();
  endtask

  // Receiver readiness cycles through steady, random and periodic stretches
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (rx_cycle % 3 == 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    i2cm_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (bus_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = bus_results.pop_front();
        if (out_tdata[0] !== want.scl_level)
          report_mismatch("scl_level", out_tdata[0], want.scl_level);
        if (out_tdata[1] !== want.sda_level)
          report_mismatch("sda_level", out_tdata[1], want.sda_level);
        if (out_tdata[9:2] !== want.read_byte)
          report_mismatch("read_byte", out_tdata[9:2], want.read_byte);
        if (out_tdata[10] !== want.busy_res)
          report_mismatch("busy_res", out_tdata[10], want.busy_res);
        if (out_tdata[12:11] !== want.status)
          report_mismatch("status", out_tdata[12:11], want.status);
        if (out_tdata[18:13] !== want.byte_total)
          report_mismatch("byte_total", out_tdata[18:13], want.byte_total);
        if (out_tdata[19] !== want.probe_ack)
          report_mismatch("probe_ack", out_tdata[19], want.probe_ack);
        if (out_tuser !== want.read_valid)
          report_mismatch("read_valid", out_tuser, want.read_valid);
        if (out_tlast !== want.done_res)
          report_mismatch("done_res", out_tlast, want.done_res);
      end
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results pending",
                 idle_cycles, bus_results.size());
        $display("i2c_master_transfer_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_buffer_fill();
    test_zero_counts();
    test_probe();
    test_write_read();
    test_address_nack();
    test_data_nack();
    test_saturated_counts();

    // drain the result queue, then let the pipeline settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bus_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("checked %0d results from %0d effective requests", n_checked, n_effective);
    $display("%0d transfers (%0d ended on a missing ack), %0d probes, %0d bytes read back",
             n_transfers, n_failed, n_probes, n_bytes_read);
    if (n_errors == 0) begin
      $display("i2c_master_transfer_tb OK");
    end else begin
      $display("i2c_master_transfer_tb NOT OK");
    end
    $finish;
  end

endmodule
